FILE: hw/rtl/thcs_pkg.sv
`timescale 1ns / 1ps

package thcs_pkg;

    // Sizing of the height set
    localparam int MAX_ITEMS   = 1024;
    localparam int HEIGHT_BITS = 20;

    // Fixed port widths
    localparam int IN_BITS  = 20;
    localparam int OUT_BITS = 20;
    localparam int REQ_BITS = 30;

    // Derived widths
    localparam int ADDR_BITS = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);
    localparam int LO_BITS   = HEIGHT_BITS + 1;
    localparam int HI_BITS   = HEIGHT_BITS + 2;
    localparam int SUM_BITS  = HEIGHT_BITS + CNT_BITS;
    localparam int CMP_BITS  = (SUM_BITS > REQ_BITS) ? SUM_BITS : REQ_BITS;

    typedef logic [HEIGHT_BITS-1:0] t_height;
    typedef logic [SUM_BITS-1:0]    t_sum;

    // Control from sequencer to accumulator
    typedef struct packed {
        logic clear;   // start of a probe pass
        logic issue;   // read request sent to the store this cycle
    } t_acc_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } t_state;

endpackage

FILE: hw/rtl/thcs_ram.sv
`timescale 1ns / 1ps

module thcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/thcs_accum.sv
`timescale 1ns / 1ps

module thcs_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  thcs_pkg::t_acc_ctl i_ctl,
    input  thcs_pkg::t_height i_rdata,
    input  thcs_pkg::t_height i_level,
    output thcs_pkg::t_sum    o_sum,
    output logic              o_busy
);

    logic              r_rd_vld;
    logic              r_exc_vld;
    thcs_pkg::t_height r_exc;
    thcs_pkg::t_sum    r_sum;
    thcs_pkg::t_height w_exc;

    // Part of the height above the probe level
    assign w_exc = (i_rdata > i_level) ? (i_rdata - i_level) : '0;

    // Valid pipeline: RAM latency, then excess stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_exc_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_ctl.issue;
            r_exc_vld <= r_rd_vld;
        end
    end

    // Excess register and running sum
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_exc <= w_exc;
        end
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (r_exc_vld) begin
            r_sum <= r_sum + thcs_pkg::SUM_BITS'(r_exc);
        end
    end

    assign o_sum  = r_sum;
    assign o_busy = r_rd_vld | r_exc_vld;

endmodule

FILE: hw/rtl/threshold_cut_height_search.sv
`timescale 1ns / 1ps
// Load: one height per cycle; a non-last request is taken back to back.
// Search: about HEIGHT_BITS+1 probes, each a pass over the N stored heights
// through the one read port of the height RAM.
// The result shows on o_done for one cycle; the receiver cannot stall it.
// Synchronous active-low reset clears count, maximum, required amount and FSM.
module threshold_cut_height_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [thcs_pkg::IN_BITS-1:0]  i_height,
    input  logic                          i_last_item,
    output logic                          o_done,
    output logic [thcs_pkg::OUT_BITS-1:0] o_cut_level,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [thcs_pkg::REQ_BITS-1:0] i_cfg_required_amount
);

    thcs_pkg::t_state r_state, n_state;
    logic [thcs_pkg::CNT_BITS-1:0] r_count, n_count;
    logic [thcs_pkg::CNT_BITS-1:0] r_scan, n_scan;
    thcs_pkg::t_height             r_max, n_max;
    thcs_pkg::t_height             r_best, n_best;
    thcs_pkg::t_height             r_mid, n_mid;
    logic [thcs_pkg::LO_BITS-1:0]  r_lo, n_lo;
    logic [thcs_pkg::HI_BITS-1:0]  r_hi, n_hi;
    logic [thcs_pkg::REQ_BITS-1:0] r_req;

    logic                          w_accept;
    logic                          w_store;
    thcs_pkg::t_height             w_h;
    logic [thcs_pkg::HI_BITS-1:0]  w_mid_sum;
    logic                          w_in_range;
    logic [thcs_pkg::CMP_BITS-1:0] w_sum_ext;
    logic [thcs_pkg::CMP_BITS-1:0] w_req_ext;
    thcs_pkg::t_acc_ctl            w_ctl;
    thcs_pkg::t_sum                w_sum;
    logic                          w_acc_busy;
    thcs_pkg::t_height             w_rdata;

    assign w_accept   = start && !busy;
    assign w_h        = thcs_pkg::HEIGHT_BITS'(i_height);
    assign w_store    = r_count < thcs_pkg::CNT_BITS'(thcs_pkg::MAX_ITEMS);
    assign w_mid_sum  = {1'b0, r_lo} + r_hi;
    assign w_in_range = $signed({1'b0, r_lo}) <= $signed(r_hi);
    assign w_sum_ext  = thcs_pkg::CMP_BITS'(w_sum);
    assign w_req_ext  = thcs_pkg::CMP_BITS'(r_req);

    // Height store
    thcs_ram #(
        .WIDTH(thcs_pkg::HEIGHT_BITS),
        .DEPTH(thcs_pkg::MAX_ITEMS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_accept && w_store),
        .i_waddr(r_count[thcs_pkg::ADDR_BITS-1:0]),
        .i_wdata(w_h),
        .i_re   (w_ctl.issue),
        .i_raddr(r_scan[thcs_pkg::ADDR_BITS-1:0]),
        .o_rdata(w_rdata)
    );

    // Excess accumulation over one pass
    thcs_accum u_accum (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_rdata(w_rdata),
        .i_level(r_mid),
        .o_sum  (w_sum),
        .o_busy (w_acc_busy)
    );

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= thcs_pkg::S_IDLE;
            r_count <= '0;
            r_max   <= '0;
            r_best  <= '0;
            r_req   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_max   <= n_max;
            r_best  <= n_best;
            if (i_cfg_valid && o_cfg_ready) begin
                r_req <= i_cfg_required_amount;
            end
        end
    end

    // Search bounds and scan pointer
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_mid  <= n_mid;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan      = r_scan;
        n_max       = r_max;
        n_best      = r_best;
        n_mid       = r_mid;
        n_lo        = r_lo;
        n_hi        = r_hi;
        w_ctl.clear = 1'b0;
        w_ctl.issue = 1'b0;
        case (r_state)
            thcs_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_store) begin
                        n_count = r_count + 1'b1;
                        if (w_h > r_max) begin
                            n_max = w_h;
                        end
                    end
                    if (i_last_item) begin
                        n_lo    = '0;
                        n_hi    = thcs_pkg::HI_BITS'(n_max);
                        n_best  = '0;
                        n_state = thcs_pkg::S_PROBE;
                    end
                end
            end
            thcs_pkg::S_PROBE: begin
                if (w_in_range) begin
                    n_mid       = w_mid_sum[thcs_pkg::HEIGHT_BITS:1];
                    n_scan      = '0;
                    w_ctl.clear = 1'b1;
                    n_state     = thcs_pkg::S_SCAN;
                end else begin
                    n_state = thcs_pkg::S_DONE;
                end
            end
            thcs_pkg::S_SCAN: begin
                if (r_scan < r_count) begin
                    w_ctl.issue = 1'b1;
                    n_scan      = r_scan + 1'b1;
                end else if (!w_acc_busy) begin
                    n_state = thcs_pkg::S_DECIDE;
                end
            end
            thcs_pkg::S_DECIDE: begin
                if (w_sum_ext > w_req_ext) begin
                    n_lo = {1'b0, r_mid} + 1'b1;
                    if (r_mid > r_best) begin
                        n_best = r_mid;
                    end
                    n_state = thcs_pkg::S_PROBE;
                end else if (w_sum_ext < w_req_ext) begin
                    n_hi    = {2'b00, r_mid} - 1'b1;
                    n_state = thcs_pkg::S_PROBE;
                end else begin
                    n_best  = r_mid;
                    n_state = thcs_pkg::S_DONE;
                end
            end
            thcs_pkg::S_DONE: begin
                n_count = '0;
                n_max   = '0;
                n_state = thcs_pkg::S_IDLE;
            end
            default: begin
                n_state = thcs_pkg::S_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != thcs_pkg::S_IDLE);
    assign o_done      = (r_state == thcs_pkg::S_DONE);
    assign o_cut_level = thcs_pkg::OUT_BITS'(r_best);
    assign o_cfg_ready = 1'b1;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= thcs_pkg::CNT_BITS'(thcs_pkg::MAX_ITEMS))
        else $error("item count beyond store depth");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_item) |=> busy)
        else $error("last item did not start the search");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy && r_count == '0))
        else $error("result strobe not single or set not cleared");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == thcs_pkg::S_DECIDE) |-> (r_mid <= r_max))
        else $error("probe level above set maximum");

    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.issue |-> (r_state == thcs_pkg::S_SCAN && r_scan < r_count))
        else $error("store read outside scan");

endmodule
